// ----- rtl/tlal_pkg.sv -----
// Shared types, sizes and codes for the toroidal life unit with age limit.
// No dependencies; every other file of the block but tlal_ram imports this package.
package tlal_pkg;

    // Grid geometry
    localparam int GRID_ROWS = 64;
    localparam int ROW_CELLS = 64;
    localparam int AGE_W     = 10;
    localparam int DATA_W    = 64;

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int ROW_CW = $clog2(GRID_ROWS + 1);
    localparam int COL_AW = $clog2(ROW_CELLS);
    localparam int COL_CW = $clog2(ROW_CELLS + 1);

    // Rule and limits
    localparam int LIFE_BIRTH  = 3;
    localparam int LIFE_STAY   = 2;
    localparam int MIN_ACTIVE  = 3;
    localparam int NBR_COUNT   = 8;
    localparam int NBR_CW      = 4;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] CFG_AGE_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_ROWS = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_COLS = 2'd2;

    localparam logic [9:0] AGE_LIMIT_RST   = 10'd600;
    localparam logic [6:0] ACTIVE_ROWS_RST = 7'd64;
    localparam logic [6:0] ACTIVE_COLS_RST = 7'd64;

    // Request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    typedef logic [ROW_CELLS-1:0]            t_row;
    typedef logic [ROW_CELLS-1:0][AGE_W-1:0] t_age_row;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [5:0]        row_index;
        logic [DATA_W-1:0] row_bits;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] row_out;
        logic [1:0]        done_kind;
    } t_out_word;

    // Three old rows around the row being updated
    typedef struct packed {
        t_row up;
        t_row mid;
        t_row dn;
    } t_window;

    typedef struct packed {
        logic [NBR_COUNT-1:0] nb;
        logic                 was;
        logic [AGE_W-1:0]     age;
    } t_lane_in;

    typedef struct packed {
        logic             alive;
        logic [AGE_W-1:0] age;
    } t_lane_out;

endpackage

// ----- rtl/tlal_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tlal_lane.sv -----
// One cell lane: B3/S23 rule plus age count, saturation and kill at the limit.
// Depends on tlal_pkg.
module tlal_lane import tlal_pkg::*; (
    input  t_lane_in         i_lane,
    input  logic [AGE_W-1:0] i_limit,
    output t_lane_out        o_lane
);

    logic [NBR_CW-1:0] cnt;
    logic              now;
    logic [AGE_W:0]    age_inc;
    logic [AGE_W-1:0]  age_sat;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < NBR_COUNT; i++) begin
            cnt = cnt + NBR_CW'(i_lane.nb[i]);
        end
        now = (cnt == NBR_CW'(LIFE_BIRTH)) || ((cnt == NBR_CW'(LIFE_STAY)) && i_lane.was);

        age_inc = {1'b0, i_lane.age} + 1'b1;
        if (age_inc > {1'b0, i_limit}) begin
            age_sat = i_limit;
        end else begin
            age_sat = age_inc[AGE_W-1:0];
        end

        if (now && (i_lane.was || (i_lane.age >= i_limit))) begin
            o_lane.age   = age_sat;
            o_lane.alive = (age_sat < i_limit);
        end else begin
            o_lane.age   = '0;
            o_lane.alive = now;
        end
    end

endmodule

// ----- rtl/tlal_row_engine.sv -----
// Row engine: one lane per cell, wrap at the active width, merge into new row words.
// Depends on tlal_pkg and tlal_lane.
module tlal_row_engine import tlal_pkg::*; (
    input  t_window           i_win,
    input  t_age_row          i_age,
    input  logic [COL_CW-1:0] i_ncols,
    input  logic [AGE_W-1:0]  i_limit,
    output t_row              o_row,
    output t_age_row          o_age
);

    logic [COL_AW-1:0] nc_m1;
    logic              wrap_up;
    logic              wrap_mid;
    logic              wrap_dn;

    assign nc_m1    = COL_AW'(i_ncols - COL_CW'(1));
    // last active column, left neighbor of column zero
    assign wrap_up  = i_win.up[nc_m1];
    assign wrap_mid = i_win.mid[nc_m1];
    assign wrap_dn  = i_win.dn[nc_m1];

    for (genvar x = 0; x < ROW_CELLS; x++) begin : g_lane
        localparam int XL = (x > 0) ? x - 1 : 0;
        localparam int XR = (x < ROW_CELLS - 1) ? x + 1 : 0;

        logic      at_left;
        logic      at_right;
        logic      active;
        logic      l_up, l_mid, l_dn;
        logic      r_up, r_mid, r_dn;
        t_lane_in  lane_in;
        t_lane_out lane_out;

        assign at_left  = (x == 0);
        assign at_right = (COL_AW'(x) == nc_m1);
        assign active   = (COL_CW'(x) < i_ncols);

        assign l_up  = at_left  ? wrap_up     : i_win.up[XL];
        assign l_mid = at_left  ? wrap_mid    : i_win.mid[XL];
        assign l_dn  = at_left  ? wrap_dn     : i_win.dn[XL];
        assign r_up  = at_right ? i_win.up[0]  : i_win.up[XR];
        assign r_mid = at_right ? i_win.mid[0] : i_win.mid[XR];
        assign r_dn  = at_right ? i_win.dn[0]  : i_win.dn[XR];

        assign lane_in.nb  = {l_up, i_win.up[x], r_up, l_mid, r_mid, l_dn, i_win.dn[x], r_dn};
        assign lane_in.was = i_win.mid[x];
        assign lane_in.age = i_age[x];

        tlal_lane u_lane (
            .i_lane  (lane_in),
            .i_limit (i_limit),
            .o_lane  (lane_out)
        );

        // hold cells outside the active width
        assign o_row[x] = active ? lane_out.alive : i_win.mid[x];
        assign o_age[x] = active ? lane_out.age   : i_age[x];
    end

endmodule

// ----- rtl/toroidal_life_with_age_limit_unit.sv -----
// From accept to result word: a write or no-op goes straight to the finish step, a read
// first passes the read step; one request is processed at a time.
// An advance sweeps one row per cycle through all lanes after priming states PRIME0 to
// PRIME2, over active_rows clamped to 3..GRID_ROWS; the grid memory port sets the pace.
// Reset (synchronous, active low) starts a pass that zeroes grid and ages one row per
// cycle; input ready stays low until it ends. Config resets to 600/64/64.
module toroidal_life_with_age_limit_unit import tlal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_PRIME0 = 8'b0000_1000,
        ST_PRIME1 = 8'b0001_0000,
        ST_PRIME2 = 8'b0010_0000,
        ST_SWEEP  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } t_state;

    // Control registers
    t_state            r_state,  n_state;
    logic [ROW_AW-1:0] r_clr,    n_clr;
    logic [ROW_AW-1:0] r_y,      n_y;
    logic              r_out_valid, n_out_valid;
    logic [9:0]        r_age_limit;
    logic [6:0]        r_active_rows;
    logic [6:0]        r_active_cols;

    // Payload registers
    t_row              r_up,     n_up;
    t_row              r_mid,    n_mid;
    t_row              r_row0,   n_row0;
    logic [1:0]        r_kind,   n_kind;
    logic              r_idx_ok, n_idx_ok;
    logic [DATA_W-1:0] r_res,    n_res;
    t_out_word         r_out_word, n_out_word;

    // Memory ports
    logic              grid_we;
    logic [ROW_AW-1:0] grid_waddr;
    t_row              grid_wdata;
    logic [ROW_AW-1:0] grid_raddr;
    t_row              grid_rdata;
    logic              age_we;
    logic [ROW_AW-1:0] age_waddr;
    t_age_row          age_wdata;
    logic [ROW_AW-1:0] age_raddr;
    t_age_row          age_rdata;

    logic              in_accept;
    logic              idx_ok;
    logic              cfg_wr;
    logic [ROW_CW-1:0] nr;
    logic [ROW_AW-1:0] nr_m1;
    logic [COL_CW-1:0] nc;
    logic              last_row;
    t_window           win;
    t_row              eng_row;
    t_age_row          eng_age;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign idx_ok     = (int'(i_in_word.row_index) < GRID_ROWS);

    // ---------------------------------------------------------------
    // Configuration port: pready always high, register i at 4*i
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit   <= AGE_LIMIT_RST;
            r_active_rows <= ACTIVE_ROWS_RST;
            r_active_cols <= ACTIVE_COLS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                CFG_AGE_LIMIT:   r_age_limit   <= pwdata[9:0];
                CFG_ACTIVE_ROWS: r_active_rows <= pwdata[6:0];
                CFG_ACTIVE_COLS: r_active_cols <= pwdata[6:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_AGE_LIMIT:   prdata = CFG_DW'(r_age_limit);
            CFG_ACTIVE_ROWS: prdata = CFG_DW'(r_active_rows);
            CFG_ACTIVE_COLS: prdata = CFG_DW'(r_active_cols);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Active area, clamped to 3..GRID_ROWS and 3..ROW_CELLS
    // ---------------------------------------------------------------
    always_comb begin
        if (int'(r_active_rows) < MIN_ACTIVE) begin
            nr = ROW_CW'(MIN_ACTIVE);
        end else if (int'(r_active_rows) > GRID_ROWS) begin
            nr = ROW_CW'(GRID_ROWS);
        end else begin
            nr = ROW_CW'(r_active_rows);
        end
        if (int'(r_active_cols) < MIN_ACTIVE) begin
            nc = COL_CW'(MIN_ACTIVE);
        end else if (int'(r_active_cols) > ROW_CELLS) begin
            nc = COL_CW'(ROW_CELLS);
        end else begin
            nc = COL_CW'(r_active_cols);
        end
    end

    assign nr_m1    = ROW_AW'(nr - ROW_CW'(1));
    assign last_row = (r_y == nr_m1);

    // ---------------------------------------------------------------
    // Storage: grid rows and per-row age vectors
    // ---------------------------------------------------------------
    tlal_ram #(
        .WIDTH (ROW_CELLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    tlal_ram #(
        .WIDTH (ROW_CELLS * AGE_W),
        .DEPTH (GRID_ROWS)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (age_raddr),
        .o_rdata (age_rdata)
    );

    // ---------------------------------------------------------------
    // Row engine. During a sweep the window holds old rows y-1 and y;
    // the row below is the word just read, or the saved old row zero
    // for the last active row (row zero is already rewritten by then).
    // ---------------------------------------------------------------
    assign win.up  = r_up;
    assign win.mid = r_mid;
    assign win.dn  = last_row ? r_row0 : grid_rdata;

    tlal_row_engine u_engine (
        .i_win   (win),
        .i_age   (age_rdata),
        .i_ncols (nc),
        .i_limit (r_age_limit),
        .o_row   (eng_row),
        .o_age   (eng_age)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_y         = r_y;
        n_up        = r_up;
        n_mid       = r_mid;
        n_row0      = r_row0;
        n_kind      = r_kind;
        n_idx_ok    = r_idx_ok;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        grid_we    = 1'b0;
        grid_waddr = r_y;
        grid_wdata = eng_row;
        grid_raddr = ROW_AW'(i_in_word.row_index);
        age_we     = 1'b0;
        age_waddr  = r_y;
        age_wdata  = eng_age;
        age_raddr  = ROW_AW'(r_y + 1'b1);

        // drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // zero one row of grid and ages per cycle
                grid_we    = 1'b1;
                grid_waddr = r_clr;
                grid_wdata = '0;
                age_we     = 1'b1;
                age_waddr  = r_clr;
                age_wdata  = '0;
                n_clr      = ROW_AW'(r_clr + 1'b1);
                if (int'(r_clr) == GRID_ROWS - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_kind   = i_in_word.req_type;
                    n_idx_ok = idx_ok;
                    n_res    = '0;
                    unique case (i_in_word.req_type)
                        REQ_WRITE: begin
                            grid_we    = idx_ok;
                            grid_waddr = ROW_AW'(i_in_word.row_index);
                            grid_wdata = i_in_word.row_bits[ROW_CELLS-1:0];
                            n_state    = ST_FINISH;
                        end
                        REQ_READ:    n_state = ST_READ;
                        REQ_ADVANCE: n_state = ST_PRIME0;
                        REQ_NONE:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_READ: begin
                n_res   = r_idx_ok ? DATA_W'(grid_rdata) : '0;
                n_state = ST_FINISH;
            end
            ST_PRIME0: begin
                // fetch the last active row, upper neighbor of row zero
                grid_raddr = nr_m1;
                n_state    = ST_PRIME1;
            end
            ST_PRIME1: begin
                grid_raddr = '0;
                n_mid      = grid_rdata;
                n_state    = ST_PRIME2;
            end
            ST_PRIME2: begin
                grid_raddr = ROW_AW'(1);
                age_raddr  = '0;
                n_up       = r_mid;
                n_mid      = grid_rdata;
                n_row0     = grid_rdata;
                n_y        = '0;
                n_state    = ST_SWEEP;
            end
            ST_SWEEP: begin
                // write row y, advance the window, fetch two rows ahead
                grid_we    = 1'b1;
                age_we     = 1'b1;
                grid_raddr = ROW_AW'(r_y + ROW_AW'(2));
                n_up       = r_mid;
                n_mid      = win.dn;
                n_y        = ROW_AW'(r_y + 1'b1);
                if (last_row) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // post the result word once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_word.row_out   = r_res;
                    n_out_word.done_kind = r_kind;
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_y         <= n_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up       <= n_up;
        r_mid      <= n_mid;
        r_row0     <= n_row0;
        r_kind     <= n_kind;
        r_idx_ok   <= n_idx_ok;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_post_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("output word posted outside the finish step");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("accepted word did not start a request");

    a_sweep_ends_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && last_row) |=> (r_state == ST_FINISH))
        else $error("sweep did not end after the last active row");

    a_sweep_stays_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (int'(r_y) < int'(nr)))
        else $error("sweep row counter left the active area");

endmodule

// ----- tb/sv/toroidal_life_with_age_limit_checker.sv -----
// Checker for the toroidal life unit: predicts every result word from the accepted
// request words and register writes, and compares it with the block's output.
// Depends on tlal_pkg for the word types, sizes and register codes.
`timescale 1ns / 1ps

module toroidal_life_with_age_limit_checker import tlal_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_word          i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_word         i_out_word,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    input  logic [CFG_DW-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    t_row             grid [GRID_ROWS];
    logic [AGE_W-1:0] ages [GRID_ROWS][ROW_CELLS];
    logic [9:0]       age_limit;
    logic [6:0]       active_rows;
    logic [6:0]       active_cols;
    t_out_word        predicted_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int clamp_size(int v, int hi);
        if (v < MIN_ACTIVE) return MIN_ACTIVE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [CFG_DW-1:0] register_value(logic [1:0] idx);
        case (idx)
            CFG_AGE_LIMIT:   return CFG_DW'(age_limit);
            CFG_ACTIVE_ROWS: return CFG_DW'(active_rows);
            CFG_ACTIVE_COLS: return CFG_DW'(active_cols);
            default:         return '0;
        endcase
    endfunction

    task automatic clear_grid();
        age_limit   = AGE_LIMIT_RST;
        active_rows = ACTIVE_ROWS_RST;
        active_cols = ACTIVE_COLS_RST;
        for (int y = 0; y < GRID_ROWS; y++) begin
            grid[y] = '0;
            for (int x = 0; x < ROW_CELLS; x++) ages[y][x] = '0;
        end
        predicted_words.delete();
    endtask

    // One B3/S23 generation over the active area, from a snapshot of the old grid
    task automatic step_generation();
        t_row prev [GRID_ROWS];
        t_row up, mid, dn;
        int   nr, nc, xl, xr, n, a;
        logic was, now;
        nr   = clamp_size(active_rows, GRID_ROWS);
        nc   = clamp_size(active_cols, ROW_CELLS);
        prev = grid;
        for (int y = 0; y < nr; y++) begin
            up  = prev[(y + nr - 1) % nr];
            mid = prev[y];
            dn  = prev[(y + 1) % nr];
            for (int x = 0; x < nc; x++) begin
                xl  = (x + nc - 1) % nc;
                xr  = (x + 1) % nc;
                was = mid[x];
                n   = int'(up[xl]) + int'(up[x]) + int'(up[xr]) + int'(mid[xl])
                    + int'(mid[xr]) + int'(dn[xl]) + int'(dn[x]) + int'(dn[xr]);
                if (n == LIFE_BIRTH) now = 1'b1;
                else if (n == LIFE_STAY) now = was;
                else now = 1'b0;
                a = ages[y][x];
                // ages above a lowered limit still count as reached, then saturate
                if (now && (was || a >= age_limit)) begin
                    a = a + 1;
                    if (a > age_limit) a = age_limit;
                    if (a >= age_limit) now = 1'b0;
                end else begin
                    a = 0;
                end
                ages[y][x] = AGE_W'(a);
                grid[y][x] = now;
            end
        end
    endtask

    task automatic apply_request(input t_in_word w);
        t_out_word r;
        r.row_out   = '0;
        r.done_kind = w.req_type;
        case (w.req_type)
            REQ_WRITE:   grid[w.row_index] = w.row_bits[ROW_CELLS-1:0];
            REQ_READ:    r.row_out = DATA_W'(grid[w.row_index]);
            REQ_ADVANCE: step_generation();
            default:     ;
        endcase
        predicted_words.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        logic [CFG_DW-1:0] rd_want;
        if (!i_rst_n) begin
            clear_grid();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("unexpected result word: row_out %h done_kind %0d",
                           i_out_word.row_out, i_out_word.done_kind);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = predicted_words.pop_front();
                    if (i_out_word.row_out !== want.row_out) begin
                        $error("row_out mismatch: expected %h, actual %h",
                               want.row_out, i_out_word.row_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_word.done_kind !== want.done_kind) begin
                        $error("done_kind mismatch: expected %0d, actual %0d",
                               want.done_kind, i_out_word.done_kind);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) apply_request(i_in_word);
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[CFG_AW-1:2])
                        CFG_AGE_LIMIT:   age_limit   = i_pwdata[9:0];
                        CFG_ACTIVE_ROWS: active_rows = i_pwdata[6:0];
                        CFG_ACTIVE_COLS: active_cols = i_pwdata[6:0];
                        default:         ;
                    endcase
                end else begin
                    rd_want = register_value(i_paddr[CFG_AW-1:2]);
                    if (i_prdata !== rd_want) begin
                        $error("prdata mismatch at %h: expected %h, actual %h",
                               i_paddr, rd_want, i_prdata);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

// ----- tb/sv/toroidal_life_with_age_limit_unit_tb.sv -----
// Top of the toroidal life unit testbench: clock, reset, request and register stimulus,
// random flow control on both channels, and the final verdict.
// Depends on tlal_pkg, the block and toroidal_life_with_age_limit_checker.
`timescale 1ns / 1ps

module toroidal_life_with_age_limit_unit_tb;
    import tlal_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 150;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_word          i_in_word;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_word         o_out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          idle_on     = 1'b1;  // random gaps on both sides when set
    bit          hold_off    = 1'b0;  // ask the receiver for one long stall
    int unsigned send_gap    = 0;     // cycles before the next request word

    toroidal_life_with_age_limit_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    toroidal_life_with_age_limit_checker life_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_word  (o_out_word),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: end the run with a failure once the cycle count reaches CYCLE_LIMIT
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: idle a random number of cycles per word, plus one long stall on request.
    // Keep the gap and the stall in one low stretch so ready gets a single update per step.
    initial begin : receiver
        int unsigned wait_cycles;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = idle_on ? $urandom_range(0, 12) : 0;
            if (hold_off) begin
                wait_cycles = wait_cycles + LONG_HOLD;
                hold_off    = 1'b0;
            end
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    function automatic t_in_word make_word(logic [1:0] kind, logic [5:0] row,
                                           logic [63:0] bits);
        t_in_word w;
        w.req_type  = kind;
        w.row_index = row;
        w.row_bits  = bits;
        return w;
    endfunction

    // Row contents of varied density so patterns live for a while before dying out
    function automatic logic [63:0] pick_row_bits();
        logic [63:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return a;
            1, 2:    return a & b;
            3:       return a & b & c;
            4:       return $urandom_range(0, 1) ? '1 : '0;
            default: return 64'h7 << $urandom_range(0, 61);
        endcase
    endfunction

    // Offer one request word at a falling edge and hold it until accepted.
    // The gap before the next word is drawn here so valid is dropped only when a gap follows.
    task automatic offer_word(input t_in_word w);
        repeat (send_gap) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        send_gap = idle_on ? $urandom_range(0, 12) : 0;
        if (send_gap > 0) i_in_valid <= 1'b0;
    endtask

    // Drop valid before a pause and set send_gap so that the next offer waits before raising it
    task automatic stop_input();
        if (send_gap == 0) begin
            i_in_valid <= 1'b0;
            send_gap = 1;
        end
    endtask

    // Hold the sender until every predicted result word has come back
    task automatic drain();
        stop_input();
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // One APB transfer: setup phase, access phase, then an idle gap
    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write a register with random junk above its width, then read it back
    task automatic program_register(input logic [1:0] idx, input int unsigned value,
                                    input int width);
        logic [CFG_DW-1:0] junk;
        junk = $urandom_range(0, 1) ? ($urandom << width) : '0;
        apb_transfer(1'b1, idx, CFG_DW'(value) | junk);
        apb_transfer(1'b0, idx, '0);
    endtask

    initial begin : stimulus
        int unsigned lim, rows, cols;
        int          nr;
        int unsigned pick;
        t_in_word    w;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset contents, full and edge rows, the unused code, wrap blinkers
        offer_word(make_word(REQ_READ, 6'd5, '0));
        offer_word(make_word(REQ_WRITE, 6'd0, '1));
        offer_word(make_word(REQ_WRITE, 6'd63, 64'h8000_0000_0000_0001));
        offer_word(make_word(REQ_READ, 6'd0, '0));
        offer_word(make_word(REQ_READ, 6'd63, '1));
        offer_word(make_word(REQ_NONE, 6'd63, '1));
        offer_word(make_word(REQ_ADVANCE, 6'd42, 64'hAAAA_5555_AAAA_5555));
        offer_word(make_word(REQ_READ, 6'd0, '0));
        offer_word(make_word(REQ_READ, 6'd63, '0));
        offer_word(make_word(REQ_READ, 6'd1, '0));
        offer_word(make_word(REQ_WRITE, 6'd0, '0));
        offer_word(make_word(REQ_WRITE, 6'd1, '0));
        offer_word(make_word(REQ_WRITE, 6'd62, '0));
        offer_word(make_word(REQ_WRITE, 6'd63, '0));
        // vertical blinker at column 5, horizontal one across the column wrap
        offer_word(make_word(REQ_WRITE, 6'd10, 64'h20));
        offer_word(make_word(REQ_WRITE, 6'd11, 64'h20));
        offer_word(make_word(REQ_WRITE, 6'd12, 64'h20));
        offer_word(make_word(REQ_WRITE, 6'd20, 64'h8000_0000_0000_0003));
        offer_word(make_word(REQ_ADVANCE, 6'd0, '0));
        offer_word(make_word(REQ_READ, 6'd11, '0));
        offer_word(make_word(REQ_READ, 6'd20, '0));
        offer_word(make_word(REQ_READ, 6'd19, '0));
        offer_word(make_word(REQ_ADVANCE, 6'd0, '0));
        offer_word(make_word(REQ_READ, 6'd10, '0));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            // Fixed settings first, extremes and out-of-range sizes among them.
            // A high limit followed by a low one leaves stored ages above the limit.
            case (ph)
                0:       begin lim = 1;    rows = 3;   cols = 3;   end
                1:       begin lim = 1023; rows = 64;  cols = 64;  end
                2:       begin lim = 0;    rows = 0;   cols = 0;   end
                3:       begin lim = 3;    rows = 127; cols = 127; end
                4:       begin lim = 2;    rows = 8;   cols = 8;   end
                5:       begin lim = 6;    rows = 16;  cols = 64;  end
                6:       begin lim = 1;    rows = 64;  cols = 3;   end
                7:       begin lim = 4;    rows = 3;   cols = 64;  end
                default: begin
                    lim  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, 15);
                    rows = $urandom_range(0, 24);
                    cols = $urandom_range(0, 127);
                end
            endcase
            program_register(CFG_AGE_LIMIT, lim, 10);
            program_register(CFG_ACTIVE_ROWS, rows, 7);
            program_register(CFG_ACTIVE_COLS, cols, 7);
            nr      = (rows < 3) ? 3 : (rows > 64) ? 64 : rows;
            idle_on = (ph % 3 != 1);

            // Seed every active row, then mostly advance and read back
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k == 40 && (ph == 4 || ph == 9)) hold_off = 1'b1;
                if (k == 75) drain();
                if (k < nr) begin
                    w = make_word(REQ_WRITE, 6'(k), pick_row_bits());
                end else begin
                    pick = $urandom_range(0, 99);
                    w.row_bits  = pick_row_bits();
                    w.row_index = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                              : 6'($urandom_range(0, nr - 1));
                    if (pick < 18) w.req_type = REQ_WRITE;
                    else if (pick < 55) w.req_type = REQ_READ;
                    else if (pick < 95) w.req_type = REQ_ADVANCE;
                    else w.req_type = REQ_NONE;
                end
                offer_word(w);
            end
        end

        // Let the last result word arrive, then watch for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
